@@ hdl/twa_pkg.sv @@
// ----------------------------------------------------------------------------
// twa_pkg
// Shared types and constants of the task worker assigner: payload structs,
// controller states and default sizes.
// ----------------------------------------------------------------------------
package twa_pkg;

    localparam int MAX_WORKERS_DEF = 16;
    localparam int TABLE_DEPTH_DEF = 64;
    localparam int COUNT_WIDTH_DEF = 16;

    localparam int KEY_W           = 32;
    localparam int CFG_W           = 5;
    localparam int WIDX_OUT_W      = 4;
    localparam int CFG_RESET_COUNT = 16;

    typedef struct packed {
        logic             is_box_task;
        logic [KEY_W-1:0] box_key;
    } twa_in_t;

    typedef struct packed {
        logic [WIDX_OUT_W-1:0] worker_index;
        logic                  entry_created;
        logic                  table_full;
    } twa_out_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_MIN,
        ST_ROUND,
        ST_COUNT,
        ST_DONE
    } state_t;

endpackage

@@ hdl/task_worker_assigner_top.sv @@
// ----------------------------------------------------------------------------
// task_worker_assigner_top
// Places tasks onto workers: box tasks per key in round robin starting at the
// least loaded worker, plain tasks on a shared wrapping pointer.
// ----------------------------------------------------------------------------
// A plain task needs no table access. A box task walks the key table one
// entry per cycle through the key RAM read port, and a hit ends the walk; a
// new key scans all used entries, then reads the box counts of the active
// workers one per cycle through the count RAM. A new key on a full table
// ends after the scan with table_full set and worker index 0. One task is
// in work at a time; a finished result waits in the output register while
// the next task is taken. The table never frees entries, so the fill count
// marks the valid ones and no clearing pass is needed; box counts carry one
// valid bit per worker.
module task_worker_assigner_top #(
    parameter int MAX_WORKERS = twa_pkg::MAX_WORKERS_DEF,
    parameter int TABLE_DEPTH = twa_pkg::TABLE_DEPTH_DEF,
    parameter int COUNT_WIDTH = twa_pkg::COUNT_WIDTH_DEF
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    cfg_wr_en,
    input  logic [twa_pkg::CFG_W-1:0] cfg_wr_data,
    input  logic                    s_valid,
    output logic                    s_ready,
    input  twa_pkg::twa_in_t        s_data,
    output logic                    m_valid,
    input  logic                    m_ready,
    output twa_pkg::twa_out_t       m_data
);

    localparam int WW    = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
    localparam int CW    = $clog2(MAX_WORKERS + 1);
    localparam int AW    = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int IW    = $clog2(TABLE_DEPTH + 1);
    localparam int XW    = (WW > twa_pkg::WIDX_OUT_W) ? WW : twa_pkg::WIDX_OUT_W;
    localparam int EW    = twa_pkg::KEY_W + WW;
    localparam int N_RST = (twa_pkg::CFG_RESET_COUNT < MAX_WORKERS) ?
                           twa_pkg::CFG_RESET_COUNT : MAX_WORKERS;

    localparam logic [CW-1:0] N_RST_C  = CW'(N_RST);
    localparam logic [WW-1:0] PP_RST_C = WW'(N_RST - 1);
    localparam logic [IW-1:0] DEPTH_C  = IW'(TABLE_DEPTH);
    localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

    twa_pkg::state_t state_reg, state_next;

    logic [twa_pkg::KEY_W-1:0] key_reg, key_next;
    logic [IW-1:0]             idx_reg, idx_next;
    logic                      cmp_vld_reg, cmp_vld_next;
    logic [AW-1:0]             cmp_idx_reg, cmp_idx_next;
    logic [AW-1:0]             slot_reg, slot_next;
    logic [IW-1:0]             used_reg, used_next;
    logic [CW-1:0]             widx_reg, widx_next;
    logic                      mv_reg, mv_next;
    logic [WW-1:0]             mi_reg, mi_next;
    logic [WW-1:0]             best_reg, best_next;
    logic [COUNT_WIDTH-1:0]    bestv_reg, bestv_next;
    logic [WW-1:0]             round_reg, round_next;
    logic [WW-1:0]             target_reg, target_next;
    logic                      created_reg, created_next;
    logic                      full_reg, full_next;
    logic [CW-1:0]             n_reg, n_next;
    logic [WW-1:0]             pp_reg, pp_next;
    logic [MAX_WORKERS-1:0]    cvalid_reg, cvalid_next;
    logic                      m_valid_reg, m_valid_next;
    twa_pkg::twa_out_t         m_data_reg, m_data_next;

    // key table RAM: {key, round}
    logic          ek_wr_en, ek_rd_en;
    logic [AW-1:0] ek_wr_addr, ek_rd_addr;
    logic [EW-1:0] ek_wr_data, ek_rd_data;
    // box count RAM
    logic                   bc_wr_en, bc_rd_en;
    logic [WW-1:0]          bc_wr_addr, bc_rd_addr;
    logic [COUNT_WIDTH-1:0] bc_wr_data, bc_rd_data;

    logic [CW-1:0] n_cfg;
    logic          accept;
    logic          hit;
    logic          scan_end;
    logic          min_end;

    twa_ram #(
        .WIDTH (EW),
        .DEPTH (TABLE_DEPTH)
    ) u_key_ram (
        .aclk    (aclk),
        .wr_en   (ek_wr_en),
        .wr_addr (ek_wr_addr),
        .wr_data (ek_wr_data),
        .rd_en   (ek_rd_en),
        .rd_addr (ek_rd_addr),
        .rd_data (ek_rd_data)
    );

    twa_ram #(
        .WIDTH (COUNT_WIDTH),
        .DEPTH (MAX_WORKERS)
    ) u_count_ram (
        .aclk    (aclk),
        .wr_en   (bc_wr_en),
        .wr_addr (bc_wr_addr),
        .wr_data (bc_wr_data),
        .rd_en   (bc_rd_en),
        .rd_addr (bc_rd_addr),
        .rd_data (bc_rd_data)
    );

    assign s_ready  = (state_reg == twa_pkg::ST_IDLE);
    assign accept   = s_valid && s_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign hit      = cmp_vld_reg && (ek_rd_data[EW-1:WW] == key_reg);
    assign scan_end = (idx_reg >= used_reg);
    assign min_end  = (widx_reg >= n_reg) && !mv_reg;

    // written count clamped into 1 .. MAX_WORKERS
    always_comb begin
        int unsigned c;
        c = int'(cfg_wr_data);
        if (c < 1) begin
            c = 1;
        end
        if (c > MAX_WORKERS) begin
            c = MAX_WORKERS;
        end
        n_cfg = CW'(c);
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            twa_pkg::ST_IDLE: begin
                if (accept) begin
                    if (!s_data.is_box_task) begin
                        state_next = twa_pkg::ST_DONE;
                    end else if (used_reg == '0) begin
                        state_next = twa_pkg::ST_MIN;
                    end else begin
                        state_next = twa_pkg::ST_SCAN;
                    end
                end
            end
            twa_pkg::ST_SCAN: begin
                if (hit) begin
                    state_next = twa_pkg::ST_ROUND;
                end else if (scan_end) begin
                    if (used_reg == DEPTH_C) begin
                        state_next = twa_pkg::ST_DONE;
                    end else begin
                        state_next = twa_pkg::ST_MIN;
                    end
                end
            end
            twa_pkg::ST_MIN: begin
                if (min_end) begin
                    state_next = twa_pkg::ST_ROUND;
                end
            end
            twa_pkg::ST_ROUND: state_next = twa_pkg::ST_COUNT;
            twa_pkg::ST_COUNT: state_next = twa_pkg::ST_DONE;
            twa_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = twa_pkg::ST_IDLE;
                end
            end
            default: state_next = twa_pkg::ST_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        logic [CW-1:0]          t_ext;
        logic [CW-1:0]          t_inc;
        logic [WW-1:0]          t;
        logic [COUNT_WIDTH-1:0] val;
        logic [XW-1:0]          widx_out;

        key_next     = key_reg;
        idx_next     = idx_reg;
        cmp_vld_next = 1'b0;
        cmp_idx_next = cmp_idx_reg;
        slot_next    = slot_reg;
        used_next    = used_reg;
        widx_next    = widx_reg;
        mv_next      = 1'b0;
        mi_next      = mi_reg;
        best_next    = best_reg;
        bestv_next   = bestv_reg;
        round_next   = round_reg;
        target_next  = target_reg;
        created_next = created_reg;
        full_next    = full_reg;
        n_next       = n_reg;
        pp_next      = pp_reg;
        cvalid_next  = cvalid_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        ek_wr_en   = 1'b0;
        ek_wr_addr = slot_reg;
        ek_wr_data = '0;
        ek_rd_en   = 1'b0;
        ek_rd_addr = idx_reg[AW-1:0];
        bc_wr_en   = 1'b0;
        bc_wr_addr = target_reg;
        bc_wr_data = '0;
        bc_rd_en   = 1'b0;
        bc_rd_addr = widx_reg[WW-1:0];

        t_ext    = '0;
        t_inc    = '0;
        t        = '0;
        val      = '0;
        widx_out = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            twa_pkg::ST_IDLE: begin
                if (accept) begin
                    key_next     = s_data.box_key;
                    idx_next     = '0;
                    widx_next    = '0;
                    created_next = 1'b0;
                    full_next    = 1'b0;
                    slot_next    = used_reg[AW-1:0];
                    if (!s_data.is_box_task) begin
                        // stale plain pointer falls back to worker 0
                        t_ext = CW'(pp_reg);
                        if (t_ext >= n_reg) begin
                            t_ext = '0;
                        end
                        t_inc = t_ext + CW'(1);
                        if (t_inc == n_reg) begin
                            t_inc = '0;
                        end
                        target_next = t_ext[WW-1:0];
                        pp_next     = t_inc[WW-1:0];
                    end
                end
            end
            twa_pkg::ST_SCAN: begin
                if (hit) begin
                    slot_next  = cmp_idx_reg;
                    round_next = ek_rd_data[WW-1:0];
                end else if (!scan_end) begin
                    ek_rd_en     = 1'b1;
                    idx_next     = idx_reg + IW'(1);
                    cmp_vld_next = 1'b1;
                    cmp_idx_next = idx_reg[AW-1:0];
                end else if (used_reg == DEPTH_C) begin
                    full_next   = 1'b1;
                    target_next = '0;
                end
            end
            twa_pkg::ST_MIN: begin
                if (widx_reg < n_reg) begin
                    bc_rd_en  = 1'b1;
                    widx_next = widx_reg + CW'(1);
                    mv_next   = 1'b1;
                    mi_next   = widx_reg[WW-1:0];
                end
                if (mv_reg) begin
                    val = cvalid_reg[mi_reg] ? bc_rd_data : '0;
                    if ((mi_reg == '0) || (val < bestv_reg)) begin
                        best_next  = mi_reg;
                        bestv_next = val;
                    end
                end
                if (min_end) begin
                    round_next   = best_reg;
                    created_next = 1'b1;
                    used_next    = used_reg + IW'(1);
                end
            end
            twa_pkg::ST_ROUND: begin
                // round pointer left over from a larger count means worker 0
                t_ext = CW'(round_reg);
                if (t_ext >= n_reg) begin
                    t_ext = '0;
                end
                t_inc = t_ext + CW'(1);
                if (t_inc == n_reg) begin
                    t_inc = '0;
                end
                t           = t_ext[WW-1:0];
                target_next = t;
                ek_wr_en    = 1'b1;
                ek_wr_addr  = slot_reg;
                ek_wr_data  = {key_reg, t_inc[WW-1:0]};
                bc_rd_en    = 1'b1;
                bc_rd_addr  = t;
            end
            twa_pkg::ST_COUNT: begin
                val        = cvalid_reg[target_reg] ? bc_rd_data : '0;
                bc_wr_en   = 1'b1;
                bc_wr_addr = target_reg;
                bc_wr_data = (val == CNT_MAX) ? val : val + COUNT_WIDTH'(1);
                cvalid_next[target_reg] = 1'b1;
            end
            twa_pkg::ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    widx_out                  = XW'(target_reg);
                    m_valid_next              = 1'b1;
                    m_data_next.worker_index  = widx_out[twa_pkg::WIDX_OUT_W-1:0];
                    m_data_next.entry_created = created_reg;
                    m_data_next.table_full    = full_reg;
                end
            end
            default: begin
            end
        endcase

        if (cfg_wr_en) begin
            n_next  = n_cfg;
            t_ext   = n_cfg - CW'(1);
            pp_next = t_ext[WW-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= twa_pkg::ST_IDLE;
            cmp_vld_reg <= 1'b0;
            mv_reg      <= 1'b0;
            used_reg    <= '0;
            n_reg       <= N_RST_C;
            pp_reg      <= PP_RST_C;
            cvalid_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            cmp_vld_reg <= cmp_vld_next;
            mv_reg      <= mv_next;
            used_reg    <= used_next;
            n_reg       <= n_next;
            pp_reg      <= pp_next;
            cvalid_reg  <= cvalid_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg     <= key_next;
        idx_reg     <= idx_next;
        cmp_idx_reg <= cmp_idx_next;
        slot_reg    <= slot_next;
        widx_reg    <= widx_next;
        mi_reg      <= mi_next;
        best_reg    <= best_next;
        bestv_reg   <= bestv_next;
        round_reg   <= round_next;
        target_reg  <= target_next;
        created_reg <= created_next;
        full_reg    <= full_next;
        m_data_reg  <= m_data_next;
    end

endmodule

@@ hdl/twa_ram.sv @@
// ----------------------------------------------------------------------------
// twa_ram
// Generic simple dual-port RAM: one write port, one read port, read data
// registered.
// ----------------------------------------------------------------------------
module twa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
